[design/fcbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_pkg
// Shared sizes, codes and types of the chained block byte stream.
// ----------------------------------------------------------------------------
package fcbs_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 1024;
  localparam int FIRST_ALLOC = 4;

  localparam int BLK_W     = $clog2(NUM_BLOCKS);
  localparam int PTR_W     = BLK_W + 1;
  localparam int POS_W     = $clog2(BLOCK_BYTES);
  localparam int LINK_W    = 16;
  localparam int STORE_AW  = BLK_W + POS_W;
  localparam int STORE_DEPTH = NUM_BLOCKS * (2 ** POS_W);

  localparam int KIND_W    = 2;
  localparam int BLOCK_FW  = 10;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [LINK_W-1:0] LINK_FREE = 16'hFFFF;
  localparam logic [LINK_W-1:0] LINK_END  = 16'h0000;
  localparam logic [LINK_W-1:0] LINK_ONE  = 16'h0002;

  typedef enum logic [KIND_W-1:0] {
    OP_OPEN  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_PUT   = 2'd2,
    OP_GET   = 2'd3
  } op_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_END  = 2'd2
  } status_t;

  typedef struct packed {
    op_kind_t                kind;
    logic                    open_ok;
    logic [BLK_W-1:0]        blk;
    logic [BYTE_W-1:0]       data;
  } op_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

[design/fcbs_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_cmd_if
// Command channel: one operation word with valid and ready.
// ----------------------------------------------------------------------------
interface fcbs_cmd_if;
  logic                                    valid;
  logic                                    ready;
  logic [fcbs_pkg::KIND_W-1:0]             kind;
  logic [fcbs_pkg::BLOCK_FW-1:0]           block_number;
  logic [fcbs_pkg::BYTE_W-1:0]             data_byte;

  modport source (output valid, output kind, output block_number, output data_byte,
                  input ready);
  modport sink (input valid, input kind, input block_number, input data_byte,
                output ready);
endinterface

[design/fcbs_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_rsp_if
// Response channel: one result word with valid and ready.
// ----------------------------------------------------------------------------
interface fcbs_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic [fcbs_pkg::BYTE_W-1:0]             read_byte;
  logic [fcbs_pkg::BLOCK_FW-1:0]           result_block;
  logic [fcbs_pkg::STATUS_W-1:0]           status;

  modport source (output valid, output read_byte, output result_block, output status,
                  input ready);
  modport sink (input valid, input read_byte, input result_block, input status,
                output ready);
endinterface

[design/fcbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/fcbs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_front
// Accepts command words and decodes them into queued operations.
// ----------------------------------------------------------------------------
module fcbs_front (
  input  logic                 clk,
  input  logic                 rst,
  fcbs_cmd_if.sink             cmd,
  input  fcbs_pkg::back_stat_t back_stat,
  input  logic                 q_full,
  output logic                 push,
  output fcbs_pkg::op_t        push_op
);

  logic ready;

  // Nothing is taken until the link table has been swept after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b0;
    end else begin
      ready <= !back_stat.clearing;
    end
  end

  assign cmd.ready = ready && !back_stat.clearing && !q_full;
  assign push      = cmd.valid && cmd.ready;

  always_comb begin
    push_op.open_ok = ({{(32 - fcbs_pkg::BLOCK_FW){1'b0}}, cmd.block_number}
                       < 32'(fcbs_pkg::NUM_BLOCKS));
    push_op.blk     = fcbs_pkg::BLK_W'(cmd.block_number);
    push_op.data    = cmd.data_byte;
    push_op.kind    = fcbs_pkg::op_kind_t'(cmd.kind);
  end

endmodule

[design/fcbs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_queue
// Short first-in first-out queue of decoded operations between the two sides.
// ----------------------------------------------------------------------------
module fcbs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  fcbs_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output fcbs_pkg::op_t head
);

  fcbs_pkg::op_t                  slots [fcbs_pkg::Q_DEPTH];
  logic [fcbs_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [fcbs_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [fcbs_pkg::Q_CNT_W-1:0]   count;

  assign full       = (count == fcbs_pkg::Q_CNT_W'(fcbs_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + fcbs_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + fcbs_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + fcbs_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - fcbs_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

[design/fcbs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbs_back
// Carries out operations on the link table and the block store, holds the
// stream position and drives the response register.
// ----------------------------------------------------------------------------
module fcbs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  fcbs_pkg::op_t        head,
  output logic                 pop,
  output fcbs_pkg::back_stat_t back_stat,
  fcbs_rsp_if.source           rsp
);

  typedef enum logic [5:0] {
    S_CLEAR       = 6'b000001,
    S_IDLE        = 6'b000010,
    S_GET_WAIT    = 6'b000100,
    S_SEARCH      = 6'b001000,
    S_SEARCH_WAIT = 6'b010000,
    S_LINK        = 6'b100000
  } state_t;

  localparam logic [fcbs_pkg::POS_W-1:0] POS_LAST = fcbs_pkg::POS_W'(fcbs_pkg::BLOCK_BYTES - 1);
  localparam logic [fcbs_pkg::BLK_W-1:0] BLK_LAST = fcbs_pkg::BLK_W'(fcbs_pkg::NUM_BLOCKS - 1);

  state_t                          state, state_next;
  logic [fcbs_pkg::BLK_W-1:0]      cur, cur_next;
  logic [fcbs_pkg::POS_W-1:0]      pos, pos_next;
  logic [fcbs_pkg::PTR_W-1:0]      ptr, ptr_next;
  logic [fcbs_pkg::BLK_W-1:0]      cnt, cnt_next;
  logic                            mode_put, mode_put_next;

  logic                            out_valid;
  logic [fcbs_pkg::BYTE_W-1:0]     out_byte;
  logic [fcbs_pkg::BLOCK_FW-1:0]   out_blk;
  fcbs_pkg::status_t               out_status;

  logic                            load;
  logic [fcbs_pkg::BYTE_W-1:0]     res_byte;
  logic [fcbs_pkg::BLK_W-1:0]      res_blk;
  fcbs_pkg::status_t               res_status;

  logic                            link_we;
  logic [fcbs_pkg::BLK_W-1:0]      link_waddr;
  logic [fcbs_pkg::LINK_W-1:0]     link_wdata;
  logic [fcbs_pkg::BLK_W-1:0]      link_raddr;
  logic [fcbs_pkg::LINK_W-1:0]     link_rdata;

  logic                            store_we;
  logic [fcbs_pkg::STORE_AW-1:0]   store_addr;
  logic [fcbs_pkg::BYTE_W-1:0]     store_rdata;

  logic                            out_free;
  logic                            link_bad;
  logic [fcbs_pkg::LINK_W-1:0]     clear_value;

  fcbs_ram #(.WIDTH(fcbs_pkg::LINK_W), .DEPTH(fcbs_pkg::NUM_BLOCKS)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  fcbs_ram #(.WIDTH(fcbs_pkg::BYTE_W), .DEPTH(fcbs_pkg::STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr),
    .wdata (head.data),
    .raddr (store_addr),
    .rdata (store_rdata)
  );

  assign back_stat.clearing = (state == S_CLEAR);
  assign out_free           = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.read_byte    = out_byte;
  assign rsp.result_block = out_blk;
  assign rsp.status       = out_status;

  // A link that ends, is free or points outside the table stops a read.
  assign link_bad = (link_rdata == fcbs_pkg::LINK_END) ||
                    (link_rdata == fcbs_pkg::LINK_FREE) ||
                    ({16'd0, link_rdata} >= 32'(fcbs_pkg::NUM_BLOCKS));

  always_comb begin
    if (cnt == fcbs_pkg::BLK_W'(1)) begin
      clear_value = fcbs_pkg::LINK_ONE;
    end else if (32'(cnt) < 32'(fcbs_pkg::FIRST_ALLOC)) begin
      clear_value = fcbs_pkg::LINK_END;
    end else begin
      clear_value = fcbs_pkg::LINK_FREE;
    end
  end

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    pos_next      = pos;
    ptr_next      = ptr;
    cnt_next      = cnt;
    mode_put_next = mode_put;
    pop           = 1'b0;
    link_we       = 1'b0;
    link_waddr    = cur;
    link_wdata    = fcbs_pkg::LINK_END;
    link_raddr    = cur;
    store_we      = 1'b0;
    store_addr    = {cur, pos};
    load          = 1'b0;
    res_byte      = '0;
    res_blk       = cur;
    res_status    = fcbs_pkg::ST_OK;

    case (state)
      S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = cnt;
        link_wdata = clear_value;
        if (cnt == BLK_LAST) begin
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + fcbs_pkg::BLK_W'(1);
        end
      end

      S_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          case (head.kind)
            fcbs_pkg::OP_OPEN: begin
              load = 1'b1;
              if (head.open_ok) begin
                cur_next = head.blk;
                pos_next = '0;
                res_blk  = head.blk;
              end
            end
            fcbs_pkg::OP_ALLOC: begin
              mode_put_next = 1'b0;
              state_next    = S_SEARCH;
            end
            fcbs_pkg::OP_PUT: begin
              store_we = 1'b1;
              if (pos == POS_LAST) begin
                mode_put_next = 1'b1;
                state_next    = S_SEARCH;
              end else begin
                pos_next = pos + fcbs_pkg::POS_W'(1);
                load     = 1'b1;
              end
            end
            fcbs_pkg::OP_GET: begin
              state_next = S_GET_WAIT;
            end
            default: ;
          endcase
        end
      end

      S_GET_WAIT: begin
        load       = 1'b1;
        res_byte   = store_rdata;
        state_next = S_IDLE;
        if (pos == POS_LAST) begin
          if (link_bad) begin
            res_status = fcbs_pkg::ST_END;
          end else begin
            cur_next = fcbs_pkg::BLK_W'(link_rdata);
            pos_next = '0;
            res_blk  = fcbs_pkg::BLK_W'(link_rdata);
          end
        end else begin
          pos_next = pos + fcbs_pkg::POS_W'(1);
        end
      end

      // Entries only ever go from free to used, so the lowest free entry
      // never moves down and the scan resumes where it last stopped.
      S_SEARCH: begin
        if (32'(ptr) >= 32'(fcbs_pkg::NUM_BLOCKS)) begin
          load       = 1'b1;
          res_status = fcbs_pkg::ST_FULL;
          res_blk    = mode_put ? cur : '0;
          state_next = S_IDLE;
        end else begin
          link_raddr = ptr[fcbs_pkg::BLK_W-1:0];
          state_next = S_SEARCH_WAIT;
        end
      end

      S_SEARCH_WAIT: begin
        if (link_rdata == fcbs_pkg::LINK_FREE) begin
          link_we = 1'b1;
          if (mode_put) begin
            link_waddr = cur;
            link_wdata = fcbs_pkg::LINK_W'(ptr);
            state_next = S_LINK;
          end else begin
            link_waddr = ptr[fcbs_pkg::BLK_W-1:0];
            link_wdata = fcbs_pkg::LINK_END;
            load       = 1'b1;
            res_blk    = ptr[fcbs_pkg::BLK_W-1:0];
            state_next = S_IDLE;
          end
        end else begin
          ptr_next   = ptr + fcbs_pkg::PTR_W'(1);
          state_next = S_SEARCH;
        end
      end

      // The new block is marked end-of-chain after the old block links to it,
      // which also covers a current block that was itself the free one.
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = ptr[fcbs_pkg::BLK_W-1:0];
        link_wdata = fcbs_pkg::LINK_END;
        cur_next   = ptr[fcbs_pkg::BLK_W-1:0];
        pos_next   = '0;
        load       = 1'b1;
        res_blk    = ptr[fcbs_pkg::BLK_W-1:0];
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cur       <= '0;
      pos       <= '0;
      ptr       <= fcbs_pkg::PTR_W'(fcbs_pkg::FIRST_ALLOC);
      cnt       <= '0;
      mode_put  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      pos      <= pos_next;
      ptr      <= ptr_next;
      cnt      <= cnt_next;
      mode_put <= mode_put_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= res_byte;
      out_blk    <= fcbs_pkg::BLOCK_FW'(res_blk);
      out_status <= res_status;
    end
  end

endmodule

[design/fat_chain_byte_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_byte_stream
// One byte stream over a block store whose blocks are chained by a link table.
// ----------------------------------------------------------------------------
// Usage:
// Command words arrive on cmd (kind, block_number, data_byte) and each one
// gives exactly one response word on rsp (read_byte, result_block, status),
// in order. A word moves when valid and ready are both high.
// After reset the link table is swept one entry per cycle while cmd.ready stays
// low; the stream then sits at block 0, position 0. A command passes the front
// decoder into a two-word queue, so the next word is taken while the back end
// is still busy. In the back end an open, or a put that does not fill its
// block, is answered in S_IDLE; a get waits in S_GET_WAIT for the registered
// read of the block store. An allocate passes S_SEARCH and S_SEARCH_WAIT, and a
// put that fills its block also S_LINK, when the first link entry tried is free;
// each used entry passed over repeats both. The scan restarts on the entry it
// last handed out, so it usually passes over that one. Entries are never freed,
// so the scan covers the table once over the life of the block; with none left
// S_SEARCH answers full. The response is registered onto rsp in the cycle after
// the back end finishes. When rsp.ready is low the response holds, the back end
// waits, and cmd keeps filling the queue until it is full.
// ----------------------------------------------------------------------------
module fat_chain_byte_stream (
  input  logic        clk,
  input  logic        rst,
  fcbs_cmd_if.sink    cmd,
  fcbs_rsp_if.source  rsp
);

  fcbs_pkg::back_stat_t back_stat;
  fcbs_pkg::op_t        push_op;
  fcbs_pkg::op_t        head;
  logic                 push;
  logic                 q_full;
  logic                 pop;
  logic                 head_valid;

  fcbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .back_stat (back_stat),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  fcbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  fcbs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .back_stat  (back_stat),
    .rsp        (rsp)
  );

endmodule

[verif/fat_chain_byte_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_byte_stream_checker
// Watches the command and response channels, keeps its own copy of the link
// table, the stored bytes and the stream cursor, and compares each response
// word with the word that this state calls for, oldest first.
// ----------------------------------------------------------------------------
module fat_chain_byte_stream_checker
  import fcbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fcbs_cmd_if         cmd,
  fcbs_rsp_if         rsp,
  output int unsigned fails,
  output int unsigned pending
);

  typedef struct {
    logic [BYTE_W-1:0]   read_byte;
    logic [BLOCK_FW-1:0] result_block;
    status_t             status;
  } rsp_word_t;

  logic [LINK_W-1:0] chain_link [NUM_BLOCKS];
  logic [BYTE_W-1:0] stream_data [int];
  int                cur_block;
  int                cur_pos;
  rsp_word_t         due_words [$];
  int unsigned       miss_count;

  initial begin
    fails      = 0;
    pending    = 0;
    miss_count = 0;
  end

  function automatic int first_free();
    for (int i = FIRST_ALLOC; i < NUM_BLOCKS; i++) begin
      if (chain_link[i] == LINK_FREE) return i;
    end
    return -1;
  endfunction

  // Applies one command word to the stream state and returns its response.
  function automatic rsp_word_t advance_stream(op_kind_t kind, logic [BLOCK_FW-1:0] blk,
                                               logic [BYTE_W-1:0] data);
    rsp_word_t w;
    int        fresh;
    int        addr;
    w.read_byte    = '0;
    w.result_block = '0;
    w.status       = ST_OK;
    addr           = cur_block * BLOCK_BYTES + cur_pos;
    case (kind)
      OP_OPEN: begin
        if (int'(blk) < NUM_BLOCKS) begin
          cur_block = int'(blk);
          cur_pos   = 0;
        end
        w.result_block = BLOCK_FW'(cur_block);
      end
      OP_ALLOC: begin
        fresh = first_free();
        if (fresh >= 0) begin
          chain_link[fresh] = LINK_END;
          w.result_block    = BLOCK_FW'(fresh);
        end else begin
          w.status = ST_FULL;
        end
      end
      OP_PUT: begin
        stream_data[addr] = data;
        if (cur_pos == BLOCK_BYTES - 1) begin
          fresh = first_free();
          if (fresh >= 0) begin
            chain_link[cur_block] = LINK_W'(fresh);
            chain_link[fresh]     = LINK_END;
            cur_block             = fresh;
            cur_pos               = 0;
          end else begin
            // No block to link: the cursor stays on the last byte.
            w.status = ST_FULL;
          end
        end else begin
          cur_pos++;
        end
        w.result_block = BLOCK_FW'(cur_block);
      end
      default: begin
        if (stream_data.exists(addr)) w.read_byte = stream_data[addr];
        if (cur_pos == BLOCK_BYTES - 1) begin
          if (chain_link[cur_block] == LINK_END || chain_link[cur_block] == LINK_FREE ||
              int'(chain_link[cur_block]) >= NUM_BLOCKS) begin
            w.status = ST_END;
          end else begin
            cur_block = int'(chain_link[cur_block]);
            cur_pos   = 0;
          end
        end else begin
          cur_pos++;
        end
        w.result_block = BLOCK_FW'(cur_block);
      end
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      for (int i = 0; i < NUM_BLOCKS; i++) chain_link[i] = LINK_FREE;
      chain_link[0] = LINK_END;
      chain_link[1] = LINK_ONE;
      chain_link[2] = LINK_END;
      chain_link[3] = LINK_END;
      stream_data.delete();
      due_words.delete();
      cur_block = 0;
      cur_pos   = 0;
    end else begin
      // Responses are taken first, so a word accepted on this edge can never
      // be matched by a response leaving on the same edge.
      if (rsp.valid && rsp.ready) begin
        if (due_words.size() == 0) begin
          miss_count++;
          if (miss_count <= 10) begin
            $display("%t: response with none outstanding: byte %0h block %0d status %0d",
                     $realtime, rsp.read_byte, rsp.result_block, rsp.status);
          end
        end else begin
          want = due_words.pop_front();
          if (rsp.read_byte !== want.read_byte || rsp.result_block !== want.result_block ||
              rsp.status !== want.status) begin
            miss_count++;
            if (miss_count <= 10) begin
              $display("%t: expected byte %0h block %0d status %0d, got byte %0h block %0d status %0d",
                       $realtime, want.read_byte, want.result_block, want.status,
                       rsp.read_byte, rsp.result_block, rsp.status);
            end
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        due_words.push_back(advance_stream(op_kind_t'(cmd.kind), cmd.block_number,
                                           cmd.data_byte));
      end
    end
    fails   <= miss_count;
    pending <= due_words.size();
  end

endmodule

[verif/fat_chain_byte_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_byte_stream_tb
// Drives open, allocate, put and get words into the chained byte stream with
// random gaps and response stalls: a short directed set, a run across a block
// boundary, random well-formed write and read runs with some noise, and the
// exhaustion of the link table. Gets are only issued for bytes already written.
// ----------------------------------------------------------------------------
module fat_chain_byte_stream_tb;
  import fcbs_pkg::*;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending_count;

  fcbs_cmd_if cmd_ch ();
  fcbs_rsp_if rsp_ch ();

  fat_chain_byte_stream dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  fat_chain_byte_stream_checker chk (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .fails   (fail_count),
    .pending (pending_count)
  );

  // Book-keeping for the stimulus only: where the cursor is, how blocks are
  // linked and which bytes hold data, so that no get reads an unwritten byte.
  int plan_link [NUM_BLOCKS];
  int plan_block;
  int plan_pos;
  bit plan_filled [int];
  int plan_heads [$];
  int calm_left;
  int words_sent;
  bit squeeze_req;
  bit squeezed;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int plan_free();
    for (int i = FIRST_ALLOC; i < NUM_BLOCKS; i++) begin
      if (plan_link[i] == int'(LINK_FREE)) return i;
    end
    return -1;
  endfunction

  function automatic bit plan_readable();
    return plan_filled.exists(plan_block * BLOCK_BYTES + plan_pos);
  endfunction

  task automatic send_word(op_kind_t kind, int blk, int data);
    int gap;
    int addr;
    int fresh;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = pause_len();
      if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.kind         <= kind;
    cmd_ch.block_number <= BLOCK_FW'(blk);
    cmd_ch.data_byte    <= BYTE_W'(data);
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    words_sent++;
    addr = plan_block * BLOCK_BYTES + plan_pos;
    case (kind)
      OP_OPEN: begin
        plan_block = blk;
        plan_pos   = 0;
      end
      OP_ALLOC: begin
        fresh = plan_free();
        if (fresh >= 0) plan_link[fresh] = int'(LINK_END);
      end
      OP_PUT: begin
        if (plan_pos == 0 && !plan_filled.exists(addr)) plan_heads.push_back(plan_block);
        plan_filled[addr] = 1'b1;
        if (plan_pos == BLOCK_BYTES - 1) begin
          fresh = plan_free();
          if (fresh >= 0) begin
            plan_link[plan_block] = fresh;
            plan_link[fresh]      = int'(LINK_END);
            plan_block            = fresh;
            plan_pos              = 0;
          end
        end else begin
          plan_pos++;
        end
      end
      default: begin
        if (plan_pos == BLOCK_BYTES - 1) begin
          if (plan_link[plan_block] != int'(LINK_END) &&
              plan_link[plan_block] != int'(LINK_FREE) &&
              plan_link[plan_block] < NUM_BLOCKS) begin
            plan_block = plan_link[plan_block];
            plan_pos   = 0;
          end
        end else begin
          plan_pos++;
        end
      end
    endcase
  endtask

  // Response side: bursts of ready with random holds, and once a long hold so
  // that the queue inside the block fills and the command side backs up.
  initial begin : rsp_drain
    int burst;
    int hold;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
        rsp_ch.ready <= 1'b1;
        repeat (burst) @(posedge clk);
        hold = pause_len();
        if (hold > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int       goal;
    int       pick;
    int       blk;
    int       len;
    op_kind_t kind;
    for (int i = 0; i < NUM_BLOCKS; i++) plan_link[i] = int'(LINK_FREE);
    plan_link[0] = int'(LINK_END);
    plan_link[1] = int'(LINK_ONE);
    plan_link[2] = int'(LINK_END);
    plan_link[3] = int'(LINK_END);
    plan_block  = 0;
    plan_pos    = 0;
    calm_left   = 0;
    words_sent  = 0;
    squeeze_req = 1'b0;
    squeezed    = 1'b0;

    rst                 <= 1'b1;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.kind         <= OP_OPEN;
    cmd_ch.block_number <= '0;
    cmd_ch.data_byte    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme bytes and block numbers, reserved and free blocks.
    send_word(OP_OPEN, 0, 'h00);
    send_word(OP_PUT, 0, 'h00);
    send_word(OP_PUT, 1023, 'hFF);
    send_word(OP_PUT, 0, 'hA5);
    send_word(OP_OPEN, 0, 'hFF);
    send_word(OP_GET, 1023, 'h00);
    send_word(OP_GET, 0, 'hFF);
    send_word(OP_GET, 0, 'h00);
    send_word(OP_ALLOC, 0, 'h00);
    send_word(OP_ALLOC, 1023, 'hFF);
    send_word(OP_OPEN, 1023, 'h00);
    send_word(OP_PUT, 0, 'h5A);
    send_word(OP_PUT, 0, 'h3C);
    send_word(OP_OPEN, 1023, 'h00);
    send_word(OP_GET, 0, 'h00);
    send_word(OP_GET, 0, 'h00);
    send_word(OP_OPEN, 'h2AA, 'h00);
    send_word(OP_PUT, 'h155, 'h55);
    send_word(OP_OPEN, 'h155, 'h00);
    send_word(OP_PUT, 'h2AA, 'hAA);
    send_word(OP_OPEN, 1, 'h00);
    send_word(OP_PUT, 0, 'h81);
    send_word(OP_OPEN, 1, 'h00);
    send_word(OP_GET, 0, 'h00);

    // Write across a block boundary so that a new block is linked, then read
    // the whole chain back through the link.
    blk = plan_free();
    send_word(OP_ALLOC, $urandom_range(0, NUM_BLOCKS - 1), $urandom_range(0, 255));
    send_word(OP_OPEN, blk, $urandom_range(0, 255));
    repeat (BLOCK_BYTES + 6) send_word(OP_PUT, $urandom_range(0, NUM_BLOCKS - 1),
                                       $urandom_range(0, 255));
    send_word(OP_OPEN, blk, $urandom_range(0, 255));
    repeat (BLOCK_BYTES + 6) send_word(OP_GET, $urandom_range(0, NUM_BLOCKS - 1),
                                       $urandom_range(0, 255));

    // Random runs: mostly an open followed by puts or by gets of written
    // bytes, with some loose words in between.
    squeeze_req = 1'b1;
    goal = words_sent + 700;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 9) < 3 && plan_free() >= 0) begin
          blk = plan_free();
          send_word(OP_ALLOC, $urandom_range(0, NUM_BLOCKS - 1), $urandom_range(0, 255));
        end else if (plan_heads.size() > 0 && $urandom_range(0, 1) == 1) begin
          blk = plan_heads[$urandom_range(0, plan_heads.size() - 1)];
        end else begin
          blk = $urandom_range(0, NUM_BLOCKS - 1);
        end
        send_word(OP_OPEN, blk, $urandom_range(0, 255));
        repeat ($urandom_range(1, 40)) send_word(OP_PUT, $urandom_range(0, NUM_BLOCKS - 1),
                                                 $urandom_range(0, 255));
      end else if (pick < 75) begin
        if (plan_heads.size() > 0) begin
          send_word(OP_OPEN, plan_heads[$urandom_range(0, plan_heads.size() - 1)],
                    $urandom_range(0, 255));
          len = $urandom_range(1, 40);
          for (int i = 0; i < len && plan_readable(); i++) begin
            send_word(OP_GET, $urandom_range(0, NUM_BLOCKS - 1), $urandom_range(0, 255));
          end
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          kind = op_kind_t'($urandom_range(0, 3));
          if (kind == OP_GET && !plan_readable()) kind = OP_PUT;
          send_word(kind, $urandom_range(0, NUM_BLOCKS - 1), $urandom_range(0, 255));
        end
      end
    end

    // Use up the link table, then fill a block with nothing left to link and
    // read it back past the end of its chain.
    while (plan_free() >= 0) begin
      send_word(OP_ALLOC, $urandom_range(0, NUM_BLOCKS - 1), $urandom_range(0, 255));
    end
    repeat (2) send_word(OP_ALLOC, $urandom_range(0, NUM_BLOCKS - 1), $urandom_range(0, 255));
    send_word(OP_OPEN, 3, $urandom_range(0, 255));
    repeat (BLOCK_BYTES + 1) send_word(OP_PUT, $urandom_range(0, NUM_BLOCKS - 1),
                                       $urandom_range(0, 255));
    send_word(OP_OPEN, 3, $urandom_range(0, 255));
    repeat (BLOCK_BYTES + 1) send_word(OP_GET, $urandom_range(0, NUM_BLOCKS - 1),
                                       $urandom_range(0, 255));
    repeat (60) begin
      kind = op_kind_t'($urandom_range(0, 3));
      if (kind == OP_GET && !plan_readable()) kind = OP_PUT;
      send_word(kind, $urandom_range(0, NUM_BLOCKS - 1), $urandom_range(0, 255));
    end

    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
design/fcbs_pkg.sv
design/fcbs_cmd_if.sv
design/fcbs_rsp_if.sv
design/fcbs_ram.sv
design/fcbs_front.sv
design/fcbs_queue.sv
design/fcbs_back.sv
design/fat_chain_byte_stream.sv
verif/fat_chain_byte_stream_checker.sv
verif/fat_chain_byte_stream_tb.sv
